>>> rtl/core/qwas_pkg.sv
`default_nettype none

package qwas_pkg;

	// event codes on cmd
	typedef enum logic [2:0] {
		CMD_MISMATCH  = 3'd0,
		CMD_INSERTION = 3'd1,
		CMD_DELETION  = 3'd2,
		CMD_SPLIT     = 3'd3,
		CMD_NONE      = 3'd4
	} cmd_t;

	// configuration register indexes
	typedef enum logic [2:0] {
		REG_OFFSET_SEL      = 3'd0,
		REG_GAP_COST        = 3'd1,
		REG_BREAK_COST      = 3'd2,
		REG_QUAL_FLOOR      = 3'd3,
		REG_MAX_QUALITY     = 3'd4,
		REG_MISSING_QUALITY = 3'd5,
		REG_MAX_SCORE       = 3'd6
	} reg_idx_t;

	localparam logic [7:0] BASE_N       = 8'd78;
	localparam logic [6:0] QUAL_OFFSET0 = 7'd33;
	localparam logic [6:0] QUAL_OFFSET1 = 7'd64;

	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	localparam int ACC_W = 32;

	// configuration register file contents
	typedef struct packed {
		logic        qual_offset_sel;
		logic [15:0] gap_cost;
		logic [15:0] break_cost;
		logic [7:0]  qual_floor;
		logic [7:0]  max_quality;
		logic [7:0]  missing_quality;
		logic [15:0] max_score;
	} cfg_t;

	// classified event passed from front to back
	typedef struct packed {
		logic [15:0] add;
		logic        last;
	} evt_t;

endpackage

`default_nettype wire

>>> rtl/core/quality_weighted_alignment_score.sv
`default_nettype none

// Quality-weighted alignment score. Alignment events are pushed in one per
// cycle while the queue is not full; each is turned into an addend at the
// input (mismatch base quality, indel or split penalty) and parked in a
// four-entry event queue, from which the accumulator takes one event per
// cycle unless a last event waits for the score register. The event marked
// last produces one score, the saturated running total clamped to max_score,
// and clears the total; other events produce no result. Sustained throughput
// is one event per clock when nothing stalls, set by the saturating add of the
// accumulator; a score passes from the event queue into the score register.
// The score register holds one result, and the event queue keeps accepting
// while a score waits to be popped until the queue fills. Configuration
// registers are written through the cfg channel, which is always ready, and
// must only be changed while no alignment is in flight.
module quality_weighted_alignment_score
	import qwas_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        push,
	output logic             full,
	input  wire logic [2:0]  cmd,
	input  wire logic [7:0]  quality_char,
	input  wire logic [7:0]  read_base,
	input  wire logic        qual_valid,
	input  wire logic        last,
	output logic             empty,
	input  wire logic        pop,
	output logic [15:0]      score,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [15:0] cfg_data
);

	cfg_t cfg_q;
	evt_t front_evt;
	evt_t queue_evt;
	logic queue_empty;
	logic queue_pop;

	assign cfg_ready = 1'b1;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.qual_offset_sel <= 1'b0;
			cfg_q.gap_cost        <= 16'd0;
			cfg_q.break_cost      <= 16'd0;
			cfg_q.qual_floor      <= 8'd0;
			cfg_q.max_quality     <= 8'd40;
			cfg_q.missing_quality <= 8'd40;
			cfg_q.max_score       <= 16'hFFFF;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_OFFSET_SEL:      cfg_q.qual_offset_sel <= cfg_data[0];
				REG_GAP_COST:        cfg_q.gap_cost        <= cfg_data;
				REG_BREAK_COST:      cfg_q.break_cost      <= cfg_data;
				REG_QUAL_FLOOR:      cfg_q.qual_floor      <= cfg_data[7:0];
				REG_MAX_QUALITY:     cfg_q.max_quality     <= cfg_data[7:0];
				REG_MISSING_QUALITY: cfg_q.missing_quality <= cfg_data[7:0];
				REG_MAX_SCORE:       cfg_q.max_score       <= cfg_data;
				default: ;
			endcase
		end
	end

	// event classification
	qwas_front u_front (
		.cmd          (cmd),
		.quality_char (quality_char),
		.read_base    (read_base),
		.qual_valid   (qual_valid),
		.last         (last),
		.cfg          (cfg_q),
		.evt          (front_evt)
	);

	// event queue between front and back
	qwas_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (push),
		.wr_data (front_evt),
		.full    (full),
		.rd_en   (queue_pop),
		.rd_data (queue_evt),
		.empty   (queue_empty)
	);

	// accumulation and result
	qwas_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.evt       (queue_evt),
		.evt_empty (queue_empty),
		.evt_pop   (queue_pop),
		.score     (score),
		.empty     (empty),
		.pop       (pop)
	);

endmodule

`default_nettype wire

>>> rtl/core/qwas_front.sv
`default_nettype none

module qwas_front
	import qwas_pkg::*;
(
	input  wire logic [2:0] cmd,
	input  wire logic [7:0] quality_char,
	input  wire logic [7:0] read_base,
	input  wire logic       qual_valid,
	input  wire logic       last,
	input  wire cfg_t       cfg,
	output evt_t            evt
);

	logic signed [9:0] qual;
	logic signed [9:0] max_q;
	logic signed [9:0] cutoff;
	logic [15:0]       mismatch_add;

	// base quality relative to the format offset, may go negative
	always_comb begin
		qual   = $signed({2'b00, quality_char})
			- $signed({3'b000, (cfg.qual_offset_sel ? QUAL_OFFSET1 : QUAL_OFFSET0)});
		max_q  = $signed({2'b00, cfg.max_quality});
		cutoff = $signed({2'b00, cfg.qual_floor});
	end

	// mismatch contribution: missing quality first, then cap, then cutoff and unknown base
	always_comb begin
		if (!qual_valid) begin
			mismatch_add = {8'd0, cfg.missing_quality};
		end else if (qual > max_q) begin
			mismatch_add = {8'd0, cfg.max_quality};
		end else if (qual < cutoff || read_base == BASE_N) begin
			mismatch_add = 16'd0;
		end else begin
			mismatch_add = {8'd0, qual[7:0]};
		end
	end

	// classify the event into an addend
	always_comb begin
		evt.last = last;
		case (cmd)
			CMD_MISMATCH:  evt.add = mismatch_add;
			CMD_INSERTION: evt.add = cfg.gap_cost;
			CMD_DELETION:  evt.add = cfg.gap_cost;
			CMD_SPLIT:     evt.add = cfg.break_cost;
			default:       evt.add = 16'd0;
		endcase
	end

endmodule

`default_nettype wire

>>> rtl/core/qwas_queue.sv
`default_nettype none

module qwas_queue
	import qwas_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic wr_en,
	input  wire evt_t wr_data,
	output logic      full,
	input  wire logic rd_en,
	output evt_t      rd_data,
	output logic      empty
);

	evt_t              mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;
	logic              do_wr;
	logic              do_rd;

	assign full    = (count_q == QCNT_W'(QDEPTH));
	assign empty   = (count_q == '0);
	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && !empty;
	assign rd_data = mem_q[rd_ptr_q];

	// entry storage
	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (do_rd) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + QCNT_W'(1);
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - QCNT_W'(1);
			end
		end
	end

endmodule

`default_nettype wire

>>> rtl/core/qwas_back.sv
`default_nettype none

module qwas_back
	import qwas_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire cfg_t        cfg,
	input  wire evt_t        evt,
	input  wire logic        evt_empty,
	output logic             evt_pop,
	output logic [15:0]      score,
	output logic             empty,
	input  wire logic        pop
);

	logic [ACC_W-1:0] acc_q;
	logic [ACC_W:0]   sum;
	logic [ACC_W-1:0] sat;
	logic [15:0]      clamped;
	logic             out_valid_q;
	logic [15:0]      score_q;
	logic             out_take;

	// saturating accumulate
	always_comb begin
		sum     = {1'b0, acc_q} + {{(ACC_W - 15){1'b0}}, evt.add};
		sat     = sum[ACC_W] ? '1 : sum[ACC_W-1:0];
		clamped = (sat > {{(ACC_W - 16){1'b0}}, cfg.max_score}) ? cfg.max_score : sat[15:0];
	end

	// a last event needs room in the result register
	assign out_take = pop && out_valid_q;
	assign evt_pop  = !evt_empty && (!evt.last || !out_valid_q || out_take);
	assign empty    = !out_valid_q;
	assign score    = score_q;

	// accumulator and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (evt_pop) begin
				acc_q <= evt.last ? '0 : sat;
			end
			if (evt_pop && evt.last) begin
				out_valid_q <= 1'b1;
			end else if (out_take) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (evt_pop && evt.last) begin
			score_q <= clamped;
		end
	end

endmodule

`default_nettype wire

>>> tb/sv/quality_weighted_alignment_score_tb.sv
`default_nettype none

module quality_weighted_alignment_score_tb;
	import qwas_pkg::*;

	localparam logic [7:0] BASE_A = 8'd65;

	// one alignment event as it appears on the input ports
	typedef struct packed {
		logic [2:0] op;
		logic [7:0] qual;
		logic [7:0] base;
		logic       has_qual;
		logic       last;
	} align_event_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        push = 1'b0;
	logic        full;
	logic [2:0]  cmd = CMD_NONE;
	logic [7:0]  quality_char = 8'd0;
	logic [7:0]  read_base = 8'd0;
	logic        qual_valid = 1'b0;
	logic        last = 1'b0;
	logic        empty;
	logic        pop = 1'b0;
	logic [15:0] score;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [2:0]  cfg_index = REG_OFFSET_SEL;
	logic [15:0] cfg_data = 16'd0;

	quality_weighted_alignment_score dut (
		.clk, .arst_n, .push, .full, .cmd, .quality_char, .read_base,
		.qual_valid, .last, .empty, .pop, .score,
		.cfg_valid, .cfg_ready, .cfg_index, .cfg_data
	);

	align_event_t pending_events[$];
	logic [15:0]  expected_scores[$];
	cfg_t         active_cfg;
	logic [31:0]  running_total = '0;
	bit           event_taken = 1'b0;
	int           tx_idle_pct = 0;
	int           rx_idle_pct = 0;
	int           error_count = 0;
	int           events_accepted = 0;
	int           scores_checked = 0;
	int           settings_applied = 0;

	// clock
	initial begin
		forever #4 clk = ~clk;
	end

	// watchdog
	initial begin
		#2000000;
		$display("Some tests failed");
		$finish;
	end

	task automatic report_error(input string msg);
		$display("ERROR at %0t: %s", $time, msg);
		error_count++;
	endtask

	// value that one event adds to the running total
	function automatic logic [15:0] event_addend(input align_event_t ev);
		int q;
		case (ev.op)
			CMD_MISMATCH: begin
				if (!ev.has_qual)
					return 16'(active_cfg.missing_quality);
				q = int'(ev.qual) - (active_cfg.qual_offset_sel ? int'(QUAL_OFFSET1)
					: int'(QUAL_OFFSET0));
				// cap wins over cutoff and 'N'
				if (q > int'(active_cfg.max_quality))
					return 16'(active_cfg.max_quality);
				if (q < int'(active_cfg.qual_floor) || ev.base == BASE_N)
					return '0;
				return 16'(q);
			end
			CMD_INSERTION, CMD_DELETION: return active_cfg.gap_cost;
			CMD_SPLIT: return active_cfg.break_cost;
			default: return '0;
		endcase
	endfunction

	// saturating accumulate, emit clamped score on the last event
	function automatic void score_event(input align_event_t ev);
		logic [32:0] sum;
		sum = {1'b0, running_total} + 33'(event_addend(ev));
		running_total = sum[32] ? '1 : sum[31:0];
		if (ev.last) begin
			expected_scores.push_back(running_total > 32'(active_cfg.max_score) ?
				active_cfg.max_score : running_total[15:0]);
			running_total = '0;
		end
	endfunction

	task automatic add_event(input logic [2:0] op, input logic [7:0] qual,
		input logic [7:0] base, input logic has_qual, input logic lst);
		pending_events.push_back('{op, qual, base, has_qual, lst});
	endtask

	// wait until the block has drained everything in flight
	task automatic wait_idle();
		while (pending_events.size() != 0 || expected_scores.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	// write every register once, only while nothing is in flight
	task automatic apply_setting(input cfg_t s);
		logic [15:0] val;
		wait_idle();
		for (int i = 0; i <= int'(REG_MAX_SCORE); i++) begin
			case (reg_idx_t'(i))
				REG_OFFSET_SEL:      val = {15'($urandom), s.qual_offset_sel};
				REG_GAP_COST:        val = s.gap_cost;
				REG_BREAK_COST:      val = s.break_cost;
				REG_QUAL_FLOOR:      val = {8'($urandom), s.qual_floor};
				REG_MAX_QUALITY:     val = {8'($urandom), s.max_quality};
				REG_MISSING_QUALITY: val = {8'($urandom), s.missing_quality};
				default:             val = s.max_score;
			endcase
			@(negedge clk);
			cfg_valid <= 1'b1;
			cfg_index <= 3'(i);
			cfg_data <= val;
			do @(posedge clk); while (!cfg_ready);
		end
		@(negedge clk);
		cfg_valid <= 1'b0;
		settings_applied++;
	endtask

	function automatic cfg_t random_setting();
		cfg_t s;
		s.qual_offset_sel = 1'($urandom);
		s.gap_cost = $urandom_range(0, 1) ? 16'($urandom) : 16'($urandom_range(0, 60));
		s.break_cost = $urandom_range(0, 1) ? 16'($urandom) : 16'($urandom_range(0, 60));
		s.qual_floor = $urandom_range(0, 3) == 0 ? 8'($urandom) : 8'($urandom_range(0, 30));
		s.max_quality = $urandom_range(0, 3) == 0 ? 8'($urandom) : 8'($urandom_range(20, 60));
		s.missing_quality = 8'($urandom);
		s.max_score = $urandom_range(0, 1) ? 16'($urandom) : 16'($urandom_range(0, 300));
		return s;
	endfunction

	// event driver: present the head of the pending queue
	always @(negedge clk) begin
		if (event_taken)
			void'(pending_events.pop_front());
		if (event_taken || !push) begin
			if (arst_n && pending_events.size() != 0 &&
				$urandom_range(0, 99) >= tx_idle_pct) begin
				push <= 1'b1;
				cmd <= pending_events[0].op;
				quality_char <= pending_events[0].qual;
				read_base <= pending_events[0].base;
				qual_valid <= pending_events[0].has_qual;
				last <= pending_events[0].last;
			end else begin
				push <= 1'b0;
			end
		end
		event_taken = 1'b0;
	end

	// score receiver
	always @(negedge clk) begin
		pop <= arst_n && ($urandom_range(0, 99) >= rx_idle_pct);
	end

	// monitor: config writes, accepted events, popped scores
	always @(posedge clk) begin : watch_ports
		align_event_t seen;
		logic [15:0] want_score;
		if (arst_n) begin
			// config transaction
			if (cfg_valid && cfg_ready) begin
				case (reg_idx_t'(cfg_index))
					REG_OFFSET_SEL:      active_cfg.qual_offset_sel = cfg_data[0];
					REG_GAP_COST:        active_cfg.gap_cost = cfg_data;
					REG_BREAK_COST:      active_cfg.break_cost = cfg_data;
					REG_QUAL_FLOOR:      active_cfg.qual_floor = cfg_data[7:0];
					REG_MAX_QUALITY:     active_cfg.max_quality = cfg_data[7:0];
					REG_MISSING_QUALITY: active_cfg.missing_quality = cfg_data[7:0];
					REG_MAX_SCORE:       active_cfg.max_score = cfg_data;
					default: ;
				endcase
			end
			// event transaction
			if (push && !full) begin
				seen = '{cmd, quality_char, read_base, qual_valid, last};
				score_event(seen);
				event_taken = 1'b1;
				events_accepted++;
			end
			// score transaction
			if (pop && !empty) begin
				if (expected_scores.size() == 0) begin
					report_error($sformatf("score %0d with none expected", score));
				end else begin
					want_score = expected_scores.pop_front();
					if (score !== want_score)
						report_error($sformatf("score %0d, expected %0d", score, want_score));
					scores_checked++;
				end
			end
		end
	end

	initial begin : run_test
		cfg_t setting;
		align_event_t ev;
		int n;
		int len;
		int offset;
		int r;

		// reset values of the registers
		active_cfg = '{qual_offset_sel: 1'b0, gap_cost: 16'd0, break_cost: 16'd0,
			qual_floor: 8'd0, max_quality: 8'd40, missing_quality: 8'd40,
			max_score: 16'hFFFF};
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed: offset 33, cutoff 10, cap 40
		tx_idle_pct = 35;
		rx_idle_pct = 46;
		setting = '{qual_offset_sel: 1'b0, gap_cost: 16'd7, break_cost: 16'd100,
			qual_floor: 8'd10, max_quality: 8'd40, missing_quality: 8'd25,
			max_score: 16'hFFFF};
		apply_setting(setting);
		add_event(CMD_MISMATCH, 8'd0, BASE_A, 1'b1, 1'b0);               // negative quality
		add_event(CMD_MISMATCH, 8'hFF, BASE_N, 1'b1, 1'b0);              // cap before 'N'
		add_event(CMD_MISMATCH, 8'(QUAL_OFFSET0 + 20), BASE_A, 1'b1, 1'b0);
		add_event(CMD_MISMATCH, 8'(QUAL_OFFSET0 + 5), BASE_A, 1'b1, 1'b0);  // below cutoff
		add_event(CMD_MISMATCH, 8'(QUAL_OFFSET0 + 10), BASE_A, 1'b1, 1'b0); // at cutoff
		add_event(CMD_MISMATCH, 8'(QUAL_OFFSET0 + 40), BASE_N, 1'b1, 1'b0); // at cap, 'N'
		add_event(CMD_MISMATCH, 8'(QUAL_OFFSET0 + 20), BASE_N, 1'b0, 1'b0); // no qualities
		add_event(CMD_INSERTION, 8'hFF, 8'hFF, 1'b1, 1'b0);
		add_event(CMD_DELETION, 8'd0, 8'd0, 1'b0, 1'b0);
		add_event(CMD_SPLIT, 8'd0, BASE_N, 1'b1, 1'b0);
		add_event(CMD_NONE, 8'hFF, BASE_A, 1'b1, 1'b0);
		add_event(3'(CMD_NONE) + 3'd1, 8'hFF, 8'hFF, 1'b1, 1'b0);     // unused codes
		add_event(3'(CMD_NONE) + 3'd3, 8'hFF, 8'hFF, 1'b1, 1'b1);
		add_event(CMD_MISMATCH, 8'hFF, BASE_N, 1'b1, 1'b1);              // one-event alignment
		add_event(CMD_NONE, 8'd0, 8'd0, 1'b0, 1'b1);                     // empty score

		// directed: offset 64, cutoff and clamps at the top
		setting = '{qual_offset_sel: 1'b1, gap_cost: 16'hFFFF, break_cost: 16'hFFFF,
			qual_floor: 8'hFF, max_quality: 8'hFF, missing_quality: 8'hFF,
			max_score: 16'd50};
		apply_setting(setting);
		add_event(CMD_MISMATCH, 8'(QUAL_OFFSET1 - 1), BASE_A, 1'b1, 1'b0);
		add_event(CMD_MISMATCH, 8'hFF, BASE_A, 1'b1, 1'b0);
		add_event(CMD_MISMATCH, 8'd0, BASE_A, 1'b0, 1'b0);
		add_event(CMD_SPLIT, 8'd0, 8'd0, 1'b0, 1'b0);
		add_event(CMD_INSERTION, 8'd0, 8'd0, 1'b0, 1'b1);               // max_score clamp
		add_event(CMD_MISMATCH, 8'hFF, BASE_N, 1'b1, 1'b1);

		// random alignments over several settings and idling profiles
		for (int phase = 0; phase < 6; phase++) begin
			tx_idle_pct = phase < 2 ? 35 : (phase < 4 ? 46 : 0);
			rx_idle_pct = phase < 2 ? 46 : (phase < 4 ? 35 : 0);
			case (phase)
				0: setting = '{qual_offset_sel: 1'b1, gap_cost: 16'hFFFF,
					break_cost: 16'hFFFF, qual_floor: 8'hFF, max_quality: 8'hFF,
					missing_quality: 8'hFF, max_score: 16'hFFFF};
				1: setting = '0;
				default: setting = random_setting();
			endcase
			apply_setting(setting);
			offset = setting.qual_offset_sel ? int'(QUAL_OFFSET1) : int'(QUAL_OFFSET0);
			n = 0;
			while (n < 150) begin
				len = $urandom_range(0, 9) == 0 ? $urandom_range(13, 40) : $urandom_range(1, 12);
				for (int k = 0; k < len; k++) begin
					r = $urandom_range(0, 99);
					if (r < 45)
						ev.op = CMD_MISMATCH;
					else if (r < 57)
						ev.op = CMD_INSERTION;
					else if (r < 69)
						ev.op = CMD_DELETION;
					else if (r < 81)
						ev.op = CMD_SPLIT;
					else if (r < 91)
						ev.op = CMD_NONE;
					else
						ev.op = 3'(CMD_NONE) + 3'($urandom_range(1, 3));
					if ($urandom_range(0, 3) == 0)
						ev.qual = 8'($urandom);
					else
						ev.qual = 8'(offset + $urandom_range(0, 70) - 5);
					ev.base = $urandom_range(0, 3) == 0 ? BASE_N : 8'($urandom);
					ev.has_qual = $urandom_range(0, 99) < 85;
					ev.last = (k == len - 1);
					pending_events.push_back(ev);
				end
				n += len;
			end
		end

		wait_idle();
		repeat (20) @(posedge clk);
		$display("covered %0d events and %0d scores over %0d register settings",
			events_accepted, scores_checked, settings_applied);
		$display("idling profiles: sender-heavy, receiver-heavy and back-to-back");
		if (error_count == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule

`default_nettype wire
